// File: rtl/tpt_pkg.sv
package tpt_pkg;

  // Fixed geometry of the 32-bit two-level table
  localparam int VA_W          = 32;
  localparam int FUNC_W        = 2;
  localparam int FRAME_W       = 20;
  localparam int FLAG_W        = 3;
  localparam int ENTRIES       = 1024;
  localparam int DIR_DEPTH     = 1024;
  localparam int IDX_W         = 10;
  localparam int DIR_LSB       = 22;
  localparam int LEAF_LSB      = 12;
  localparam int TABLE_POOL_DEF = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_MAP    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNMAP  = 2'd2;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIR,
    ST_LEAF
  } state_t;

  // One second-level entry as stored in the leaf memory
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
    logic [FLAG_W-1:0]  flags;
  } leaf_entry_t;

endpackage

// File: rtl/tpt_ifs.sv
interface tpt_req_if;
  logic                         valid;
  logic                         ready;
  logic [tpt_pkg::FUNC_W-1:0]   func;
  logic [tpt_pkg::VA_W-1:0]     virt_addr;
  logic [tpt_pkg::FRAME_W-1:0]  frame_in;
  logic [tpt_pkg::FLAG_W-1:0]   req_flags;

  modport source (output valid, func, virt_addr, frame_in, req_flags, input ready);
  modport sink (input valid, func, virt_addr, frame_in, req_flags, output ready);
endinterface

interface tpt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [tpt_pkg::FRAME_W-1:0]  frame_out;
  logic [tpt_pkg::FLAG_W-1:0]   found_flags;

  modport source (output valid, ok, frame_out, found_flags, input ready);
  modport sink (input valid, ok, frame_out, found_flags, output ready);
endinterface

// File: rtl/tpt_dir_ram.sv
module tpt_dir_ram #(
  parameter int W = 5
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [tpt_pkg::IDX_W-1:0]   waddr,
  input  logic [W-1:0]                wdata,
  input  logic                        re,
  input  logic [tpt_pkg::IDX_W-1:0]   raddr,
  output logic [W-1:0]                rdata
);

  logic [W-1:0] mem [tpt_pkg::DIR_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tpt_leaf_ram.sv
module tpt_leaf_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  tpt_pkg::leaf_entry_t  wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output tpt_pkg::leaf_entry_t  rdata
);

  tpt_pkg::leaf_entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/two_level_page_table_engine_unit.sv
// Two-level page table engine. Each request beat is a map, lookup or unmap of one
// 4 KiB page; each one returns exactly one response beat. For a request the
// directory memory is read, then the leaf memory is read or written at the
// table the directory entry names; both memories have registered read ports.
// One request is in flight at a time, and the next is taken while the previous
// response still waits in the output register. Second-level tables come from a
// pool of TABLE_POOL tables in order and are never returned. After reset the
// engine runs a clearing pass over all TABLE_POOL*1024 leaf entries (16384 by
// default), one leaf entry per cycle, during which req.ready stays low.
module two_level_page_table_engine_unit #(
  parameter int TABLE_POOL = tpt_pkg::TABLE_POOL_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tpt_req_if.sink    req,
  tpt_rsp_if.source  rsp
);

  localparam int TW         = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int PNW        = $clog2(TABLE_POOL + 1);
  localparam int LEAF_DEPTH = TABLE_POOL * tpt_pkg::ENTRIES;
  localparam int LAW        = $clog2(LEAF_DEPTH);
  localparam int DIR_W      = TW + 1;

  tpt_pkg::state_t state, state_next;

  logic [LAW-1:0]                sweep_cnt;
  logic [PNW-1:0]                pool_next, pool_next_next;
  logic [tpt_pkg::FUNC_W-1:0]    func_q;
  logic [tpt_pkg::IDX_W-1:0]     dir_idx_q;
  logic [tpt_pkg::IDX_W-1:0]     leaf_idx_q;
  logic [tpt_pkg::FRAME_W-1:0]   frame_q;
  logic [tpt_pkg::FLAG_W-1:0]    flags_q;
  logic                          dir_hit_q;
  logic                          ok_q, ok_next;

  logic                          rsp_valid, rsp_valid_next;
  logic                          rsp_ok;
  logic [tpt_pkg::FRAME_W-1:0]   rsp_frame;
  logic [tpt_pkg::FLAG_W-1:0]    rsp_flags;

  logic                          dir_we, dir_re;
  logic [tpt_pkg::IDX_W-1:0]     dir_waddr;
  logic [DIR_W-1:0]              dir_wdata, dir_rdata;
  logic                          leaf_we, leaf_re;
  logic [LAW-1:0]                leaf_addr;
  tpt_pkg::leaf_entry_t          leaf_wdata, leaf_rdata;

  logic                          accept, out_free, pool_full, dir_present;
  logic [TW-1:0]                 dir_tidx, tidx_sel;
  logic [LAW-1:0]                slot;
  logic                          res_ok, is_lookup;

  assign accept      = req.valid && req.ready;
  assign out_free    = !rsp_valid || rsp.ready;
  assign pool_full   = (pool_next == PNW'(TABLE_POOL));
  assign dir_present = dir_rdata[TW];
  assign dir_tidx    = dir_rdata[TW-1:0];
  assign tidx_sel    = dir_present ? dir_tidx : TW'(pool_next);
  assign slot        = LAW'({tidx_sel, leaf_idx_q});
  assign is_lookup   = (func_q == tpt_pkg::FUNC_LOOKUP);
  assign res_ok      = is_lookup ? (dir_hit_q && leaf_rdata.present) : ok_q;

  tpt_dir_ram #(.W(DIR_W)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (req.virt_addr[tpt_pkg::DIR_LSB +: tpt_pkg::IDX_W]),
    .rdata (dir_rdata)
  );

  tpt_leaf_ram #(.DEPTH(LEAF_DEPTH), .AW(LAW)) u_leaf (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_addr),
    .wdata (leaf_wdata),
    .re    (leaf_re),
    .raddr (leaf_addr),
    .rdata (leaf_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpt_pkg::ST_SWEEP: if (sweep_cnt == LAW'(LEAF_DEPTH - 1)) state_next = tpt_pkg::ST_IDLE;
      tpt_pkg::ST_IDLE:  if (req.valid) state_next = tpt_pkg::ST_DIR;
      tpt_pkg::ST_DIR:   state_next = tpt_pkg::ST_LEAF;
      tpt_pkg::ST_LEAF:  if (out_free) state_next = tpt_pkg::ST_IDLE;
      default:           state_next = tpt_pkg::ST_SWEEP;
    endcase
  end

  // Memory controls, pool allocation and the early result of map and unmap
  always_comb begin
    req.ready      = 1'b0;
    dir_re         = 1'b0;
    dir_we         = 1'b0;
    dir_waddr      = sweep_cnt[tpt_pkg::IDX_W-1:0];
    dir_wdata      = '0;
    leaf_we        = 1'b0;
    leaf_re        = 1'b0;
    leaf_addr      = slot;
    leaf_wdata     = '0;
    pool_next_next = pool_next;
    ok_next        = ok_q;
    unique case (state)
      tpt_pkg::ST_SWEEP: begin
        dir_we    = 1'b1;
        leaf_we   = 1'b1;
        leaf_addr = sweep_cnt;
      end
      tpt_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        dir_re    = req.valid;
      end
      tpt_pkg::ST_DIR: begin
        ok_next = 1'b0;
        unique case (func_q)
          tpt_pkg::FUNC_MAP: begin
            if (dir_present || !pool_full) begin
              ok_next    = 1'b1;
              leaf_we    = 1'b1;
              leaf_wdata = '{present: 1'b1, frame: frame_q, flags: flags_q};
            end
            // Take the next table of the pool for an absent directory entry
            if (!dir_present && !pool_full) begin
              dir_we         = 1'b1;
              dir_waddr      = dir_idx_q;
              dir_wdata      = {1'b1, TW'(pool_next)};
              pool_next_next = pool_next + PNW'(1);
            end
          end
          tpt_pkg::FUNC_LOOKUP: begin
            leaf_re = dir_present;
          end
          tpt_pkg::FUNC_UNMAP: begin
            ok_next = dir_present;
            leaf_we = dir_present;
          end
          default: begin
            ok_next = 1'b0;
          end
        endcase
      end
      tpt_pkg::ST_LEAF: begin
      end
      default: begin
      end
    endcase
  end

  // Output register valid: load on finish, drop when taken
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (state == tpt_pkg::ST_LEAF && out_free) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpt_pkg::ST_SWEEP;
      sweep_cnt <= '0;
      pool_next <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pool_next <= pool_next_next;
      rsp_valid <= rsp_valid_next;
      if (state == tpt_pkg::ST_SWEEP) begin
        sweep_cnt <= sweep_cnt + LAW'(1);
      end
    end
  end

  // Hold the request fields of the beat in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= req.func;
      leaf_idx_q <= req.virt_addr[tpt_pkg::LEAF_LSB +: tpt_pkg::IDX_W];
      frame_q    <= req.frame_in;
      flags_q    <= req.req_flags;
    end
    if (state == tpt_pkg::ST_DIR) begin
      dir_hit_q <= dir_present;
      ok_q      <= ok_next;
    end
  end

  // The directory write address needs the directory index, kept apart from the leaf index
  always_ff @(posedge clk) begin
    if (accept) begin
      dir_idx_q <= req.virt_addr[tpt_pkg::DIR_LSB +: tpt_pkg::IDX_W];
    end
  end

  // Response payload register
  always_ff @(posedge clk) begin
    if (state == tpt_pkg::ST_LEAF && out_free) begin
      rsp_ok    <= res_ok;
      rsp_frame <= (is_lookup && res_ok) ? leaf_rdata.frame : '0;
      rsp_flags <= (is_lookup && res_ok) ? leaf_rdata.flags : '0;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.frame_out   = rsp_frame;
  assign rsp.found_flags = rsp_flags;

endmodule

// File: rtl/tpt_checker.sv
module tpt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_ok,
  input logic [tpt_pkg::FRAME_W-1:0]  rsp_frame_out,
  input logic [tpt_pkg::FLAG_W-1:0]   rsp_found_flags
);

  // No response beat comes out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // A failed operation carries no frame and no marks
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ok) |-> (rsp_frame_out == '0 && rsp_found_flags == '0))
    else $error("failed response with nonzero payload");

  // One request in flight: no beat is taken while the one before is in its directory and leaf steps
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
    else $error("request taken while another is in flight");

  // A stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_ok) && $stable(rsp_frame_out) && $stable(rsp_found_flags)))
    else $error("stalled response changed");

endmodule

bind two_level_page_table_engine_unit tpt_checker u_tpt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_ok          (rsp.ok),
  .rsp_frame_out   (rsp.frame_out),
  .rsp_found_flags (rsp.found_flags)
);

// File: tb/sv/tb_top.sv
module tb_top;
  import tpt_pkg::*;

  localparam int POOL = TABLE_POOL_DEF;
  localparam int LEAF_DEPTH = POOL * ENTRIES;
  localparam int STALL_LIMIT = 100000;
  localparam int RANDOM_OPS = 1900;
  // Unused operation code: the engine must answer all zero and change nothing
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame;
    logic [FLAG_W-1:0]  flags;
  } reply_t;

  logic clk;
  logic rst;

  tpt_req_if req_bus ();
  tpt_rsp_if rsp_bus ();

  two_level_page_table_engine_unit #(
    .TABLE_POOL(POOL)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Shadow copy of the page table
  bit                        dir_live [DIR_DEPTH];
  int unsigned               dir_tbl [DIR_DEPTH];
  bit                        leaf_live [LEAF_DEPTH];
  logic [FRAME_W+FLAG_W-1:0] leaf_word [LEAF_DEPTH];
  int unsigned               tables_used;

  reply_t pending_replies[$];
  int     errors;
  bit     quiet;
  int     stall_cycles;
  int     map_ok, map_fail, lookup_hit, lookup_miss, unmap_ok, unmap_fail, noop_cnt;

  // Random-address working set, so that most items land in live tables
  logic [IDX_W-1:0] hot_dir [20];
  logic [IDX_W-1:0] hot_leaf [24];

  always #5 clk = ~clk;

  // Compute the reply of one operation and update the shadow table
  function automatic reply_t apply_table_op(logic [FUNC_W-1:0] f, logic [VA_W-1:0] va,
                                            logic [FRAME_W-1:0] fr, logic [FLAG_W-1:0] fl);
    int unsigned d;
    int unsigned slot;
    reply_t r;
    d = va[31:DIR_LSB];
    r = '0;
    case (f)
      FUNC_MAP: begin
        if (!dir_live[d] && tables_used < POOL) begin
          dir_tbl[d] = tables_used;
          dir_live[d] = 1'b1;
          tables_used++;
        end
        if (dir_live[d]) begin
          slot = dir_tbl[d] * ENTRIES + va[DIR_LSB-1:LEAF_LSB];
          leaf_live[slot] = 1'b1;
          leaf_word[slot] = {fr, fl};
          r.ok = 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        if (dir_live[d]) begin
          slot = dir_tbl[d] * ENTRIES + va[DIR_LSB-1:LEAF_LSB];
          if (leaf_live[slot]) begin
            r.ok = 1'b1;
            r.frame = leaf_word[slot][FRAME_W+FLAG_W-1:FLAG_W];
            r.flags = leaf_word[slot][FLAG_W-1:0];
          end
        end
      end
      FUNC_UNMAP: begin
        if (dir_live[d]) begin
          slot = dir_tbl[d] * ENTRIES + va[DIR_LSB-1:LEAF_LSB];
          leaf_live[slot] = 1'b0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one request beat and record its reply once accepted; valid stays high
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [VA_W-1:0] va,
                         input logic [FRAME_W-1:0] fr, input logic [FLAG_W-1:0] fl);
    reply_t r;
    while (!quiet && $urandom_range(0, 99) < 10) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.func      <= f;
    req_bus.virt_addr <= va;
    req_bus.frame_in  <= fr;
    req_bus.req_flags <= fl;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    r = apply_table_op(f, va, fr, fl);
    pending_replies.push_back(r);
    case (f)
      FUNC_MAP:    if (r.ok) map_ok++; else map_fail++;
      FUNC_LOOKUP: if (r.ok) lookup_hit++; else lookup_miss++;
      FUNC_UNMAP:  if (r.ok) unmap_ok++; else unmap_fail++;
      default:     noop_cnt++;
    endcase
  endtask

  // Hold the request side until every reply is back
  task automatic drain_replies();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_op(FUNC_LOOKUP, 32'h0000_0000, '0, '0);
    send_op(FUNC_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_op(FUNC_UNMAP,  32'h0040_0000, '0, '0);
  endtask

  task automatic test_map_lookup();
    send_op(FUNC_MAP,    32'h0000_0000, 20'h00000, 3'd0);
    send_op(FUNC_LOOKUP, 32'h0000_0000, '0, '0);
    send_op(FUNC_MAP,    32'hFFFF_FFFF, 20'hFFFFF, 3'd7);
    send_op(FUNC_LOOKUP, 32'hFFFF_F123, '0, '0);
    send_op(FUNC_MAP,    32'h0000_1000, 20'hABCDE, 3'd5);
    send_op(FUNC_LOOKUP, 32'h0000_1FFF, '0, '0);
    // overwrite an existing mapping
    send_op(FUNC_MAP,    32'h0000_0000, 20'h12345, 3'd2);
    send_op(FUNC_LOOKUP, 32'h0000_0ABC, '0, '0);
    // directory present, leaf absent
    send_op(FUNC_LOOKUP, 32'h0000_2000, '0, '0);
  endtask

  task automatic test_unmap();
    send_op(FUNC_UNMAP,  32'h0000_1000, '0, '0);
    send_op(FUNC_LOOKUP, 32'h0000_1000, '0, '0);
    // leaf already clear: still succeeds
    send_op(FUNC_UNMAP,  32'h0000_1000, '0, '0);
    send_op(FUNC_UNMAP,  32'h8000_0000, '0, '0);
    send_op(FUNC_LOOKUP, 32'hFFFF_F000, '0, '0);
  endtask

  task automatic test_unused_func();
    send_op(FUNC_NONE,   32'hFFFF_FFFF, 20'hFFFFF, 3'd7);
    send_op(FUNC_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_op(FUNC_NONE,   32'h4000_0000, 20'h55555, 3'd3);
  endtask

  // Same entry on consecutive beats with no gaps on either side
  task automatic test_back_to_back();
    quiet = 1'b1;
    send_op(FUNC_MAP,    32'h00C0_3000, 20'h3C3C3, 3'd6);
    send_op(FUNC_LOOKUP, 32'h00C0_3000, '0, '0);
    send_op(FUNC_UNMAP,  32'h00C0_3000, '0, '0);
    send_op(FUNC_LOOKUP, 32'h00C0_3000, '0, '0);
    send_op(FUNC_MAP,    32'h00C0_3000, 20'hC3C3C, 3'd1);
    send_op(FUNC_LOOKUP, 32'h00C0_3000, '0, '0);
    quiet = 1'b0;
    drain_replies();
  endtask

  task automatic test_random(input int n);
    int unsigned pick;
    logic [FUNC_W-1:0] f;
    logic [VA_W-1:0] va;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3) && (i < n / 3 + 300);
      pick = $urandom_range(0, 99);
      if (pick < 40) f = FUNC_MAP;
      else if (pick < 75) f = FUNC_LOOKUP;
      else if (pick < 95) f = FUNC_UNMAP;
      else f = FUNC_NONE;
      va = $urandom;
      // fresh directories are rare on map so the pool lasts through most of the run
      if ($urandom_range(0, 99) >= ((f == FUNC_MAP) ? 3 : 10))
        va[31:LEAF_LSB] = {hot_dir[$urandom_range(0, 19)], hot_leaf[$urandom_range(0, 23)]};
      send_op(f, va, 20'($urandom), 3'($urandom));
      if (i % 250 == 249) drain_replies();
    end
    quiet = 1'b0;
  endtask

  task automatic test_pool_exhaustion();
    logic [IDX_W-1:0] d;
    while (tables_used < POOL) begin
      d = 10'($urandom);
      if (!dir_live[d]) send_op(FUNC_MAP, {d, 22'($urandom)}, 20'($urandom), 3'($urandom));
    end
    do d = 10'($urandom); while (dir_live[d]);
    send_op(FUNC_MAP,    {d, 22'h2A_5A5}, 20'hFFFFF, 3'd7);
    send_op(FUNC_LOOKUP, {d, 22'h2A_5A5}, '0, '0);
    send_op(FUNC_UNMAP,  {d, 22'h2A_5A5}, '0, '0);
    send_op(FUNC_MAP,    32'hFFFF_E000, 20'h0F0F0, 3'd4);
    send_op(FUNC_LOOKUP, 32'hFFFF_E000, '0, '0);
    drain_replies();
  endtask

  // Random backpressure on the reply side
  always @(posedge clk) begin
    rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  // Compare each reply beat against the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none outstanding: ok=%0b frame=%h flags=%0d", $time,
                 rsp_bus.ok, rsp_bus.frame_out, rsp_bus.found_flags);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp_bus.ok !== want.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_bus.ok);
          errors++;
        end
        if (rsp_bus.frame_out !== want.frame) begin
          $display("%0t: frame_out expected %h actual %h", $time, want.frame,
                   rsp_bus.frame_out);
          errors++;
        end
        if (rsp_bus.found_flags !== want.flags) begin
          $display("%0t: found_flags expected %0d actual %0d", $time, want.flags,
                   rsp_bus.found_flags);
          errors++;
        end
      end
    end
  end

  // End the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    quiet = 1'b0;
    errors = 0;
    stall_cycles = 0;
    tables_used = 0;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_MAP;
    req_bus.virt_addr = '0;
    req_bus.frame_in = '0;
    req_bus.req_flags = '0;
    rsp_bus.ready = 1'b0;
    foreach (hot_dir[i]) hot_dir[i] = 10'($urandom);
    foreach (hot_leaf[i]) hot_leaf[i] = 10'($urandom);
    hot_dir[0] = '0;
    hot_dir[1] = '1;
    hot_leaf[0] = '0;
    hot_leaf[1] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_map_lookup();
    test_unmap();
    test_unused_func();
    test_back_to_back();
    test_random(RANDOM_OPS);
    test_pool_exhaustion();

    // Hold after the last reply to catch stray beats
    drain_replies();
    repeat (20) @(posedge clk);

    $display("Covered %0d maps (%0d refused), %0d lookups (%0d hits), %0d unmaps, %0d no-ops",
             map_ok + map_fail, map_fail, lookup_hit + lookup_miss, lookup_hit,
             unmap_ok + unmap_fail, noop_cnt);
    $display("Table pool use: %0d of %0d tables", tables_used, POOL);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
